// File: hdl/sid_pkg.sv
// ----------------------------------------------------------------------------
// sid_pkg
// Shared types for the pipelined signed integer divider.
// ----------------------------------------------------------------------------
package sid_pkg;

    // Per-request side information that travels with the magnitudes.
    typedef struct packed {
        logic neg;   // Operand signs differ, so the quotient is negated.
        logic zero;  // Quotient is forced to zero (zero divisor or dividend).
    } sid_flags_t;

endpackage

// File: hdl/sid_prep.sv
// ----------------------------------------------------------------------------
// sid_prep
// Input stage: takes the operand magnitudes and the sign and zero flags.
// ----------------------------------------------------------------------------
module sid_prep #(
    parameter int WIDTH = 32
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    valid_i,
    output logic                    ready_o,
    input  logic signed [WIDTH-1:0] dividend,
    input  logic signed [WIDTH-1:0] divisor,
    output logic                    valid_o,
    input  logic                    ready_i,
    output logic [WIDTH-1:0]        rem_o,
    output logic [WIDTH-1:0]        den_o,
    output sid_pkg::sid_flags_t     flags_o
);

    logic [WIDTH-1:0]    num_raw;
    logic [WIDTH-1:0]    den_raw;
    logic [WIDTH-1:0]    num_mag_next;
    logic [WIDTH-1:0]    den_mag_next;
    sid_pkg::sid_flags_t flags_next;
    logic                valid_reg;
    logic [WIDTH-1:0]    num_mag_reg;
    logic [WIDTH-1:0]    den_mag_reg;
    sid_pkg::sid_flags_t flags_reg;
    logic                load;

    // The stage takes a new request when empty or when its content moves on.
    assign ready_o = !valid_reg || ready_i;
    assign load    = valid_i && ready_o;

    // Magnitudes in unsigned form; the most negative value maps to 2^(WIDTH-1).
    always_comb
    begin
        num_raw         = dividend;
        den_raw         = divisor;
        num_mag_next    = num_raw[WIDTH-1] ? (~num_raw + 1'b1) : num_raw;
        den_mag_next    = den_raw[WIDTH-1] ? (~den_raw + 1'b1) : den_raw;
        flags_next.neg  = num_raw[WIDTH-1] ^ den_raw[WIDTH-1];
        flags_next.zero = (den_raw == '0) || (num_raw == '0);
    end

    // Valid bit of the stage.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (ready_o)
        begin
            valid_reg <= valid_i;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            num_mag_reg <= num_mag_next;
            den_mag_reg <= den_mag_next;
            flags_reg   <= flags_next;
        end
    end

    assign valid_o = valid_reg;
    assign rem_o   = num_mag_reg;
    assign den_o   = den_mag_reg;
    assign flags_o = flags_reg;

endmodule

// File: hdl/sid_stage.sv
// ----------------------------------------------------------------------------
// sid_stage
// One restoring step: decides one quotient bit and updates the remainder.
// ----------------------------------------------------------------------------
module sid_stage #(
    parameter int WIDTH = 32,
    parameter int BIT   = 31
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                valid_i,
    output logic                ready_o,
    input  logic [WIDTH-1:0]    rem_i,
    input  logic [WIDTH-1:0]    quo_i,
    input  logic [WIDTH-1:0]    den_i,
    input  sid_pkg::sid_flags_t flags_i,
    output logic                valid_o,
    input  logic                ready_i,
    output logic [WIDTH-1:0]    rem_o,
    output logic [WIDTH-1:0]    quo_o,
    output logic [WIDTH-1:0]    den_o,
    output sid_pkg::sid_flags_t flags_o
);

    localparam logic [WIDTH-1:0] ONE      = {{(WIDTH-1){1'b0}}, 1'b1};
    localparam logic [WIDTH-1:0] LOW_MASK = (ONE << BIT) - ONE;

    logic                upper;
    logic [WIDTH-1:0]    rem_shift;
    logic [WIDTH-1:0]    rem_next;
    logic [WIDTH-1:0]    quo_next;
    logic                valid_reg;
    logic [WIDTH-1:0]    rem_reg;
    logic [WIDTH-1:0]    quo_reg;
    logic [WIDTH-1:0]    den_reg;
    sid_pkg::sid_flags_t flags_reg;
    logic                load;

    assign ready_o = !valid_reg || ready_i;
    assign load    = valid_i && ready_o;

    // Trial subtraction of the divisor aligned to this bit. When it fits,
    // the shifted divisor is no larger than the remainder, so no bits are lost.
    always_comb
    begin
        rem_shift = rem_i >> BIT;
        upper     = (rem_shift >= den_i);
        rem_next  = upper ? (rem_i - (den_i << BIT)) : rem_i;
        quo_next  = quo_i | ({{(WIDTH-1){1'b0}}, upper} << BIT);
    end

    // Valid bit of the stage.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (ready_o)
        begin
            valid_reg <= valid_i;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            rem_reg   <= rem_next;
            quo_reg   <= quo_next;
            den_reg   <= den_i;
            flags_reg <= flags_i;
        end
    end

    assign valid_o = valid_reg;
    assign rem_o   = rem_reg;
    assign quo_o   = quo_reg;
    assign den_o   = den_reg;
    assign flags_o = flags_reg;

    // Bits below this step have not been decided yet.
    assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg |-> ((quo_reg & LOW_MASK) == '0))
    else $error("quotient bits below the current step are set");

    // After the step the aligned remainder is smaller than a nonzero divisor.
    assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && !flags_reg.zero) |-> ((rem_reg >> BIT) < den_reg))
    else $error("remainder not reduced below the aligned divisor");

endmodule

// File: hdl/sid_fix.sv
// ----------------------------------------------------------------------------
// sid_fix
// Output stage: applies the sign and the zero cases, holds the result.
// ----------------------------------------------------------------------------
module sid_fix #(
    parameter int WIDTH = 32
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    valid_i,
    output logic                    ready_o,
    input  logic [WIDTH-1:0]        quo_i,
    input  sid_pkg::sid_flags_t     flags_i,
    output logic                    valid_o,
    input  logic                    ready_i,
    output logic signed [WIDTH-1:0] quotient
);

    logic [WIDTH-1:0] quotient_next;
    logic [WIDTH-1:0] quotient_reg;
    logic             valid_reg;
    logic             load;

    assign ready_o = !valid_reg || ready_i;
    assign load    = valid_i && ready_o;

    // Sign fix; the most negative value over minus one wraps naturally.
    always_comb
    begin
        if (flags_i.zero)
        begin
            quotient_next = '0;
        end
        else if (flags_i.neg)
        begin
            quotient_next = ~quo_i + 1'b1;
        end
        else
        begin
            quotient_next = quo_i;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (ready_o)
        begin
            valid_reg <= valid_i;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            quotient_reg <= quotient_next;
        end
    end

    assign valid_o  = valid_reg;
    assign quotient = $signed(quotient_reg);

endmodule

// File: hdl/signed_integer_divider_unit.sv
// ----------------------------------------------------------------------------
// signed_integer_divider_unit
// Pipelined signed divider, quotient truncated toward zero.
//
//   Channel   Handshake               Payload
//   input     in_valid / in_ready     dividend, divisor
//   output    out_valid / out_ready   quotient
//
// One request enters per cycle unless a stalled output backs the pipe up; its
// quotient is presented after passing WIDTH + 2 register stages (input stage,
// one restoring stage per quotient bit, sign-fix stage). Every stage holds a
// valid bit and is reloaded when empty or when its content moves on, so a
// stall at the output fills the empty stages first and then holds every
// stage in place. Reset clears all valid bits only.
// ----------------------------------------------------------------------------
module signed_integer_divider_unit #(
    parameter int WIDTH = 32
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic signed [WIDTH-1:0] dividend,
    input  logic signed [WIDTH-1:0] divisor,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic signed [WIDTH-1:0] quotient
);

    // Stage k hands its content to stage k + 1; index 0 is the input stage.
    logic                valid [0:WIDTH];
    logic                ready [0:WIDTH];
    logic [WIDTH-1:0]    rem   [0:WIDTH];
    logic [WIDTH-1:0]    quo   [0:WIDTH];
    logic [WIDTH-1:0]    den   [0:WIDTH];
    sid_pkg::sid_flags_t flags [0:WIDTH];

    // Input stage.
    sid_prep #(
        .WIDTH (WIDTH)
    ) u_prep (
        .clk      (clk),
        .rst_n    (rst_n),
        .valid_i  (in_valid),
        .ready_o  (in_ready),
        .dividend (dividend),
        .divisor  (divisor),
        .valid_o  (valid[0]),
        .ready_i  (ready[0]),
        .rem_o    (rem[0]),
        .den_o    (den[0]),
        .flags_o  (flags[0])
    );

    assign quo[0] = '0;

    // One restoring stage per quotient bit, top bit first.
    for (genvar k = 0; k < WIDTH; k++)
    begin : g_stage
        sid_stage #(
            .WIDTH (WIDTH),
            .BIT   (WIDTH - 1 - k)
        ) u_stage (
            .clk     (clk),
            .rst_n   (rst_n),
            .valid_i (valid[k]),
            .ready_o (ready[k]),
            .rem_i   (rem[k]),
            .quo_i   (quo[k]),
            .den_i   (den[k]),
            .flags_i (flags[k]),
            .valid_o (valid[k+1]),
            .ready_i (ready[k+1]),
            .rem_o   (rem[k+1]),
            .quo_o   (quo[k+1]),
            .den_o   (den[k+1]),
            .flags_o (flags[k+1])
        );
    end

    // Sign fix and output register.
    sid_fix #(
        .WIDTH (WIDTH)
    ) u_fix (
        .clk      (clk),
        .rst_n    (rst_n),
        .valid_i  (valid[WIDTH]),
        .ready_o  (ready[WIDTH]),
        .quo_i    (quo[WIDTH]),
        .flags_i  (flags[WIDTH]),
        .valid_o  (out_valid),
        .ready_i  (out_ready),
        .quotient (quotient)
    );

    // The input side only stalls when the whole pipe is full behind a stalled output.
    assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> (out_valid && !out_ready))
    else $error("input stalled while the output is free");

endmodule

// File: tb/tb_signed_integer_divider_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_signed_integer_divider_unit
// Self-checking bench for the pipelined signed divider. A directed set of
// corner cases comes first: zero operands, equal operands, the most-negative
// value on either side, and the wrapping most-negative by minus one case.
// Random divisions with assorted magnitudes and signs follow. Every accepted
// request is predicted by a bit-level restoring divider in the bench, and
// each quotient is checked in order against the oldest prediction. Both
// handshakes idle at random, the output is held off long enough to back the
// pipeline up into the input, and the input pauses twice for a full drain.
// ----------------------------------------------------------------------------
module tb_signed_integer_divider_unit;

    localparam int W                = 32;
    localparam int PIPE_LATENCY     = W + 2;
    localparam int LONG_HOLD_AT     = 390;
    localparam int LONG_HOLD_CYCLES = 300;
    localparam int CYCLE_LIMIT      = 200000;
    localparam int RANDOM_REQUESTS  = 925;

    localparam logic [W-1:0] MOST_NEG = {1'b1, {(W-1){1'b0}}};
    localparam logic [W-1:0] MOST_POS = {1'b0, {(W-1){1'b1}}};

    // One pending division with the idle time the sender spends before it.
    typedef struct {
        logic [W-1:0] dividend;
        logic [W-1:0] divisor;
        int           gap;
        bit           drain;
    } division_request_t;

    // Predicted quotient, kept with its operands for reporting.
    typedef struct {
        logic [W-1:0] dividend;
        logic [W-1:0] divisor;
        logic [W-1:0] quotient;
    } quotient_prediction_t;

    logic                clk       = 1'b0;
    logic                rst_n     = 1'b0;
    logic                in_valid  = 1'b0;
    logic                in_ready;
    logic signed [W-1:0] dividend  = '0;
    logic signed [W-1:0] divisor   = '0;
    logic                out_valid;
    logic                out_ready = 1'b0;
    logic signed [W-1:0] quotient;

    division_request_t    pending_requests[$];
    quotient_prediction_t predicted_quotients[$];
    int                   error_count   = 0;
    int                   results_seen  = 0;
    int                   cycle_count   = 0;

    signed_integer_divider_unit #(
        .WIDTH     (W)
    ) i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .dividend  (dividend),
        .divisor   (divisor),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .quotient  (quotient)
    );

    // Clock, 12 ns period.
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Quotient truncated toward zero, by restoring division of the magnitudes.
    function automatic logic [W-1:0] predict_quotient(input logic [W-1:0] num,
                                                      input logic [W-1:0] den);
        logic [W-1:0] num_mag;
        logic [W-1:0] den_mag;
        logic [W-1:0] partial;
        logic [W-1:0] quo;
        int           bit_pos;
        if (num == '0 || den == '0)
        begin
            return '0;
        end
        num_mag = num[W-1] ? -num : num;
        den_mag = den[W-1] ? -den : den;
        partial = num_mag;
        quo     = '0;
        for (bit_pos = W - 1; bit_pos >= 0; bit_pos--)
        begin
            if ((partial >> bit_pos) >= den_mag)
            begin
                partial      = partial - (den_mag << bit_pos);
                quo[bit_pos] = 1'b1;
            end
        end
        return (num[W-1] != den[W-1]) ? -quo : quo;
    endfunction

    // Operand drawn from the boundary values, small values or the full range.
    function automatic logic [W-1:0] random_operand();
        logic [W-1:0] value;
        case ($urandom_range(0, 7))
            0: value = '0;
            1: value = 1;
            2: value = '1;
            3: value = MOST_NEG;
            4: value = MOST_POS;
            5: value = $urandom_range(0, 255);
            default: value = $urandom();
        endcase
        if ($urandom_range(0, 5) == 0)
        begin
            value = -value;
        end
        return value;
    endfunction

    // Queue a request. Two windows run without sender gaps: a plain burst and
    // the one that keeps offering requests while the output is held off.
    task automatic add_request(input logic [W-1:0] num, input logic [W-1:0] den);
        division_request_t req;
        int                idx;
        idx          = pending_requests.size();
        req.dividend = num;
        req.divisor  = den;
        if ((idx >= 200 && idx < 260) || (idx >= 380 && idx < 520))
        begin
            req.gap = 0;
        end
        else
        begin
            req.gap = $urandom_range(0, 15);
        end
        req.drain = (idx == 25) || (idx == 700);
        pending_requests.push_back(req);
    endtask

    // Sender: offers pending requests, records a prediction for each accepted one.
    always @(posedge clk)
    begin
        division_request_t    req;
        quotient_prediction_t pred;
        bit                   offering;
        int                   idle_cycles;
        if (!rst_n)
        begin
            in_valid    <= 1'b0;
            idle_cycles = 0;
        end
        else
        begin
            offering = in_valid;
            if (in_valid && in_ready)
            begin
                pred.dividend = dividend;
                pred.divisor  = divisor;
                pred.quotient = predict_quotient(dividend, divisor);
                predicted_quotients.push_back(pred);
                offering    = 1'b0;
                idle_cycles = 0;
            end
            if (!offering)
            begin
                if (pending_requests.size() > 0
                    && idle_cycles >= pending_requests[0].gap
                    && (!pending_requests[0].drain || predicted_quotients.size() == 0))
                begin
                    req      = pending_requests.pop_front();
                    dividend <= req.dividend;
                    divisor  <= req.divisor;
                    offering = 1'b1;
                end
                else
                begin
                    idle_cycles++;
                end
            end
            in_valid <= offering;
        end
    end

    // Receiver: checks each quotient, then stalls for a drawn number of cycles.
    always @(posedge clk)
    begin
        quotient_prediction_t oldest;
        int                   hold_cycles;
        if (!rst_n)
        begin
            out_ready   <= 1'b0;
            hold_cycles = 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (predicted_quotients.size() == 0)
                begin
                    $display("%0t: unexpected quotient: expected none, actual %0d",
                             $time, quotient);
                    error_count++;
                end
                else
                begin
                    oldest = predicted_quotients.pop_front();
                    if (quotient !== oldest.quotient)
                    begin
                        $display("%0t: quotient of %0d / %0d: expected %0d, actual %0d",
                                 $time, $signed(oldest.dividend), $signed(oldest.divisor),
                                 $signed(oldest.quotient), quotient);
                        error_count++;
                    end
                end
                results_seen++;
                // One long hold-off backs the pipeline up into the input.
                if (results_seen == LONG_HOLD_AT)
                begin
                    hold_cycles = LONG_HOLD_CYCLES;
                end
                else if (results_seen >= 600 && results_seen < 700)
                begin
                    hold_cycles = 0;
                end
                else
                begin
                    hold_cycles = $urandom_range(0, 15);
                end
            end
            else if (hold_cycles > 0)
            begin
                hold_cycles--;
            end
            out_ready <= (hold_cycles == 0);
        end
    end

    // Watchdog on the total run length.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    // Stimulus, reset and end of run.
    initial
    begin
        logic [W-1:0] num;
        logic [W-1:0] den;
        int           n;

        // Zero operands, equal operands and the most-negative corner cases.
        add_request('0, '0);
        add_request('0, 5);
        add_request(5, '0);
        add_request(MOST_NEG, '0);
        add_request(MOST_NEG, '1);
        add_request(MOST_NEG, MOST_NEG);
        add_request(7, MOST_NEG);
        add_request(-7, MOST_NEG);
        add_request(MOST_POS, MOST_NEG);
        add_request(MOST_NEG, 1);
        add_request(MOST_NEG, 2);
        add_request(MOST_NEG, -2);
        add_request(MOST_NEG, MOST_POS);
        add_request(MOST_POS, 1);
        add_request(MOST_POS, '1);
        add_request(MOST_POS, MOST_POS);
        add_request('1, '1);
        add_request(12345, 12345);
        add_request(-999, -999);
        add_request(7, 2);
        add_request(-7, 2);
        add_request(7, -2);
        add_request(-7, -2);
        add_request(1, MOST_POS);
        add_request(MOST_POS, 2);

        // Random divisions over several operand shapes.
        for (n = 0; n < RANDOM_REQUESTS; n++)
        begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3:
                begin
                    num = $urandom();
                    den = $urandom();
                end
                4, 5:
                begin
                    num = $urandom();
                    den = $urandom_range(1, 1000);
                    if ($urandom_range(0, 1))
                    begin
                        den = -den;
                    end
                end
                6:
                begin
                    num = $urandom();
                    den = num;
                end
                7:
                begin
                    num = random_operand();
                    den = random_operand();
                end
                8:
                begin
                    num = $urandom();
                    den = 1 << $urandom_range(0, W - 2);
                    if ($urandom_range(0, 1))
                    begin
                        den = -den;
                    end
                end
                default:
                begin
                    num = $urandom() >> $urandom_range(0, W - 1);
                    den = $urandom() >> $urandom_range(0, W - 1);
                    if ($urandom_range(0, 1))
                    begin
                        num = -num;
                    end
                    if ($urandom_range(0, 1))
                    begin
                        den = -den;
                    end
                end
            endcase
            add_request(num, den);
        end

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // Wait for every request to be taken and every quotient to be checked.
        while (pending_requests.size() > 0 || in_valid || predicted_quotients.size() > 0)
        begin
            @(posedge clk);
        end
        repeat (PIPE_LATENCY + 8) @(posedge clk);

        // Anything still outstanding after the drain window is a lost quotient.
        if (pending_requests.size() > 0 || in_valid || predicted_quotients.size() > 0)
        begin
            $display("%0t: outstanding quotients: expected 0, actual %0d",
                     $time, predicted_quotients.size());
            error_count++;
        end

        if (error_count == 0)
        begin
            $display("status: pass");
        end
        else
        begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

// File: files.f
hdl/sid_pkg.sv
hdl/sid_prep.sv
hdl/sid_stage.sv
hdl/sid_fix.sv
hdl/signed_integer_divider_unit.sv
tb/tb_signed_integer_divider_unit.sv
